// ===== src/vos_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel occupancy package
// Shared request and response types, opcodes, controller states and the
// command and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package vos_pkg;

  // Default edge length of the cube, in cells.
  localparam int RES_DEFAULT = 16;

  // Width of signed bound arithmetic: covers an 8-bit centre plus or minus RES.
  localparam int SW = 10;

  // Width of the removed-cell count.
  localparam int CNT_W = 13;

  // Opcodes.
  localparam logic [1:0] OP_TEST  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CARVE = 2'd2;

  // One request item.
  typedef struct packed {
    logic [1:0]        opcode;
    logic signed [7:0] coord_x;
    logic signed [7:0] coord_y;
    logic signed [7:0] coord_z;
    logic              new_value;
    logic [7:0]        radius;
  } vos_req_t;

  // One result item.
  typedef struct packed {
    logic             flag;
    logic [CNT_W-1:0] removed_count;
  } vos_rsp_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_DISPATCH,
    ST_CELL,
    ST_CARVE,
    ST_DRAIN,
    ST_FINISH
  } vos_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_step;
    logic capture;
    logic cell_read;
    logic cell_finish;
    logic carve_load;
    logic carve_step;
    logic carve_finish;
    logic zero_finish;
  } vos_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_last;
    logic is_cell;
    logic is_carve;
    logic walk_last;
  } vos_stat_t;

endpackage

// ===== src/vos_ctrl.sv =====
// ----------------------------------------------------------------------------
// Voxel occupancy controller
// State machine that sequences the fill pass after reset, request decode,
// single-cell access and the sphere walk, and drives the datapath commands.
// ----------------------------------------------------------------------------
module vos_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  vos_pkg::vos_stat_t stat,
  output vos_pkg::vos_cmd_t  cmd
);

  vos_pkg::vos_state_t state;
  vos_pkg::vos_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vos_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      vos_pkg::ST_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.init_last) begin
          state_next = vos_pkg::ST_IDLE;
        end
      end
      vos_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = vos_pkg::ST_DECODE;
        end
      end
      vos_pkg::ST_DECODE: begin
        // Bounds and the cell address settle in the datapath this cycle.
        state_next = vos_pkg::ST_DISPATCH;
      end
      vos_pkg::ST_DISPATCH: begin
        priority if (stat.is_cell) begin
          cmd.cell_read = 1'b1;
          state_next    = vos_pkg::ST_CELL;
        end else if (stat.is_carve) begin
          cmd.carve_load = 1'b1;
          state_next     = vos_pkg::ST_CARVE;
        end else begin
          cmd.zero_finish = 1'b1;
          state_next      = vos_pkg::ST_IDLE;
        end
      end
      vos_pkg::ST_CELL: begin
        cmd.cell_finish = 1'b1;
        state_next      = vos_pkg::ST_IDLE;
      end
      vos_pkg::ST_CARVE: begin
        cmd.carve_step = 1'b1;
        if (stat.walk_last) begin
          state_next = vos_pkg::ST_DRAIN;
        end
      end
      vos_pkg::ST_DRAIN: begin
        // The last visited cell is resolved in the datapath this cycle.
        state_next = vos_pkg::ST_FINISH;
      end
      vos_pkg::ST_FINISH: begin
        cmd.carve_finish = 1'b1;
        state_next       = vos_pkg::ST_IDLE;
      end
      default: begin
        state_next = vos_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/vos_dp.sv =====
// ----------------------------------------------------------------------------
// Voxel occupancy datapath
// Holds the occupancy memory, the request register, the bounding box, the
// walk counters, the distance pipeline and the result register.
// ----------------------------------------------------------------------------
module vos_dp #(
  parameter int RES = vos_pkg::RES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  vos_pkg::vos_cmd_t cmd,
  output vos_pkg::vos_stat_t stat,
  input  vos_pkg::vos_req_t req,
  output vos_pkg::vos_rsp_t rsp,
  output logic              done
);

  localparam int CELLS = RES * RES * RES;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(RES);
  localparam int RW    = $clog2(RES + 1);
  localparam int QW    = 2 * RW;
  localparam int DW    = QW + 2;
  localparam int SW    = vos_pkg::SW;

  localparam logic [AW-1:0]        LAST_ADDR = AW'(CELLS - 1);
  localparam logic signed [SW-1:0] MAX_C     = SW'(RES - 1);
  localparam logic [CW-1:0]        MAX_CELL  = CW'(RES - 1);

  // Request register.
  vos_pkg::vos_req_t req_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
  end

  // Clamp the radius and form signed centre values.
  logic [RW-1:0]        r_c;
  logic signed [SW-1:0] r_s;
  logic signed [SW-1:0] cx_s;
  logic signed [SW-1:0] cy_s;
  logic signed [SW-1:0] cz_s;

  always_comb begin
    r_c  = (req_q.radius > 8'(RES)) ? RW'(RES) : req_q.radius[RW-1:0];
    r_s  = $signed({{(SW - RW){1'b0}}, r_c});
    cx_s = SW'(req_q.coord_x);
    cy_s = SW'(req_q.coord_y);
    cz_s = SW'(req_q.coord_z);
  end

  // Per-axis bounding box, clipped to the cube.
  logic signed [SW-1:0] xlo_s, xhi_s, ylo_s, yhi_s, zlo_s, zhi_s;
  logic                 box_empty;
  logic                 cell_inside;

  always_comb begin
    xlo_s = cx_s - r_s;
    xhi_s = cx_s + r_s;
    ylo_s = cy_s - r_s;
    yhi_s = cy_s + r_s;
    zlo_s = cz_s - r_s;
    zhi_s = cz_s + r_s;
    box_empty = (xhi_s < 0) || (xlo_s > MAX_C) ||
                (yhi_s < 0) || (ylo_s > MAX_C) ||
                (zhi_s < 0) || (zlo_s > MAX_C);
    cell_inside = (cx_s >= 0) && (cx_s <= MAX_C) &&
                  (cy_s >= 0) && (cy_s <= MAX_C) &&
                  (cz_s >= 0) && (cz_s <= MAX_C);
  end

  // Bound registers, refreshed every cycle from the held request.
  logic [RW-1:0] r_q;
  logic [QW-1:0] r2_q;
  logic [CW-1:0] xlo, xhi, ylo, yhi, zlo, zhi;
  logic          empty_q;
  logic          inside_q;
  logic [AW-1:0] cell_addr;

  always_ff @(posedge clk) begin
    r_q      <= r_c;
    r2_q     <= QW'(r_q) * QW'(r_q);
    xlo      <= (xlo_s < 0) ? '0 : xlo_s[CW-1:0];
    ylo      <= (ylo_s < 0) ? '0 : ylo_s[CW-1:0];
    zlo      <= (zlo_s < 0) ? '0 : zlo_s[CW-1:0];
    xhi      <= (xhi_s > MAX_C) ? MAX_CELL : xhi_s[CW-1:0];
    yhi      <= (yhi_s > MAX_C) ? MAX_CELL : yhi_s[CW-1:0];
    zhi      <= (zhi_s > MAX_C) ? MAX_CELL : zhi_s[CW-1:0];
    empty_q  <= box_empty;
    inside_q <= cell_inside;
    cell_addr <= AW'((AW'(cz_s[CW-1:0]) * AW'(RES) + AW'(cy_s[CW-1:0])) * AW'(RES)
                     + AW'(cx_s[CW-1:0]));
  end

  // Walk counters over the clipped box: x fastest, then z, then y.
  logic [CW-1:0] wx, wy, wz;
  logic          walk_last;

  assign walk_last = (wx == xhi) && (wy == yhi) && (wz == zhi);

  always_ff @(posedge clk) begin
    if (cmd.carve_load) begin
      wx <= xlo;
      wy <= ylo;
      wz <= zlo;
    end else if (cmd.carve_step) begin
      if (wx != xhi) begin
        wx <= wx + 1'b1;
      end else begin
        wx <= xlo;
        if (wz != zhi) begin
          wz <= wz + 1'b1;
        end else begin
          wz <= zlo;
          wy <= wy + 1'b1;
        end
      end
    end
  end

  // Address and squared offsets of the cell being visited.
  logic [AW-1:0]        walk_addr;
  logic signed [SW-1:0] dx, dy, dz;
  logic [SW-1:0]        adx, ady, adz;
  logic [RW-1:0]        mx, my, mz;

  always_comb begin
    walk_addr = AW'((AW'(wz) * AW'(RES) + AW'(wy)) * AW'(RES) + AW'(wx));
    dx  = $signed({{(SW - CW){1'b0}}, wx}) - cx_s;
    dy  = $signed({{(SW - CW){1'b0}}, wy}) - cy_s;
    dz  = $signed({{(SW - CW){1'b0}}, wz}) - cz_s;
    adx = (dx < 0) ? SW'(-dx) : SW'(dx);
    ady = (dy < 0) ? SW'(-dy) : SW'(dy);
    adz = (dz < 0) ? SW'(-dz) : SW'(dz);
    // Inside the clipped box every offset is at most the clamped radius.
    mx  = adx[RW-1:0];
    my  = ady[RW-1:0];
    mz  = adz[RW-1:0];
  end

  // First walk stage: squares and address, aligned with the memory read.
  logic          p1_valid;
  logic [QW-1:0] p1_sqx, p1_sqy, p1_sqz;
  logic [AW-1:0] p1_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= cmd.carve_step;
    end
  end

  always_ff @(posedge clk) begin
    p1_sqx  <= QW'(mx) * QW'(mx);
    p1_sqy  <= QW'(my) * QW'(my);
    p1_sqz  <= QW'(mz) * QW'(mz);
    p1_addr <= walk_addr;
  end

  // Occupancy memory, one bit per cell.
  logic          mem [CELLS];
  logic          mem_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_data;
  logic [AW-1:0] init_addr;
  logic [DW-1:0] dist_sq;
  logic          hit;

  // Second walk stage: distance test against the occupied bit.
  always_comb begin
    dist_sq = DW'(p1_sqx) + DW'(p1_sqy) + DW'(p1_sqz);
    hit     = p1_valid && (dist_sq <= DW'(r2_q)) && mem_q;
  end

  assign rd_en   = cmd.carve_step | cmd.cell_read;
  assign rd_addr = cmd.carve_step ? walk_addr : cell_addr;

  // Write port select.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cell_addr;
    wr_data = 1'b0;
    priority if (cmd.init_step) begin
      wr_en   = 1'b1;
      wr_addr = init_addr;
      wr_data = 1'b1;
    end else if (hit) begin
      wr_en   = 1'b1;
      wr_addr = p1_addr;
      wr_data = 1'b0;
    end else if (cmd.cell_finish && (req_q.opcode == vos_pkg::OP_SET)) begin
      wr_en   = 1'b1;
      wr_addr = cell_addr;
      wr_data = req_q.new_value;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Fill pass address after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_addr <= '0;
    end else if (cmd.init_step) begin
      init_addr <= init_addr + 1'b1;
    end
  end

  // Count of cleared cells, wrapping at its width.
  logic [vos_pkg::CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (cmd.carve_load) begin
      count <= '0;
    end else if (hit) begin
      count <= count + 1'b1;
    end
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.cell_finish | cmd.carve_finish | cmd.zero_finish;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.cell_finish) begin
      rsp.flag          <= (req_q.opcode == vos_pkg::OP_SET) ?
                           (mem_q != req_q.new_value) : mem_q;
      rsp.removed_count <= '0;
    end else if (cmd.carve_finish) begin
      rsp.flag          <= 1'b0;
      rsp.removed_count <= count;
    end else if (cmd.zero_finish) begin
      rsp.flag          <= 1'b0;
      rsp.removed_count <= '0;
    end else begin
      rsp <= rsp;
    end
  end

  // Status to the controller.
  always_comb begin
    stat.init_last = (init_addr == LAST_ADDR);
    stat.is_cell   = ((req_q.opcode == vos_pkg::OP_TEST) ||
                      (req_q.opcode == vos_pkg::OP_SET)) && inside_q;
    stat.is_carve  = (req_q.opcode == vos_pkg::OP_CARVE) && !empty_q;
    stat.walk_last = walk_last;
  end

endmodule

// ===== src/voxel_occupancy_sphere_carve_core.sv =====
// ----------------------------------------------------------------------------
// Voxel occupancy sphere carve core
// Cubic occupancy bitmap with cell test, cell set and sphere clear.
//
// A request is taken on req at a rising edge where start is high and busy is
// low. Every request gives one result on rsp, marked by done for one cycle;
// the receiver cannot stall it and the result register holds until the next.
// Test and set of a cell inside the cube pass through the decode, dispatch
// and cell states, with done in the cycle after the cell state. Requests that
// touch no cell (coordinate outside the cube, empty clipped box, unused
// opcode) return from dispatch straight to idle. A sphere clear visits one
// cell of its clipped bounding box per cycle through the bit memory, which
// reads one cell while it clears the cell read before.
// After reset a fill pass writes every cell to occupied, one cell a cycle;
// busy stays high during it.
// ----------------------------------------------------------------------------
module voxel_occupancy_sphere_carve_core #(
  parameter int RES = vos_pkg::RES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  vos_pkg::vos_req_t req,
  output logic              done,
  output vos_pkg::vos_rsp_t rsp
);

  vos_pkg::vos_cmd_t  cmd;
  vos_pkg::vos_stat_t stat;

  // Sequencing.
  vos_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Storage and arithmetic.
  vos_dp #(
    .RES (RES)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp),
    .done (done)
  );

endmodule

// ===== verif/voxel_occupancy_checker.sv =====
// ----------------------------------------------------------------------------
// Voxel occupancy checker
// Watches the request and result channels of the sphere carve core. It keeps
// its own copy of the occupancy bitmap, predicts the result of every accepted
// request and compares each result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module voxel_occupancy_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  vos_pkg::vos_req_t          req,
  input  logic                       done,
  input  vos_pkg::vos_rsp_t          rsp,
  output int                         fail_count,
  output int                         outstanding
);

  localparam int RES          = vos_pkg::RES_DEFAULT;
  localparam int CELLS        = RES * RES * RES;
  localparam int REPORT_LIMIT = 10;

  // Shadow bitmap, one bit per cell, indexed as (z * RES + y) * RES + x.
  logic              occupied [CELLS];
  vos_pkg::vos_rsp_t pending_results [$];
  int                failures = 0;

  function automatic bit in_cube(int x, int y, int z);
    return x >= 0 && y >= 0 && z >= 0 && x < RES && y < RES && z < RES;
  endfunction

  // Clears every occupied cell of the clipped sphere and returns how many it cleared.
  function automatic int carve_sphere(int cx, int cy, int cz, int rad);
    int r, r2, x_lo, x_hi, y_lo, y_hi, z_lo, z_hi, cleared, idx;
    r       = (rad > RES) ? RES : rad;
    r2      = r * r;
    x_lo    = (cx - r < 0) ? 0 : cx - r;
    y_lo    = (cy - r < 0) ? 0 : cy - r;
    z_lo    = (cz - r < 0) ? 0 : cz - r;
    x_hi    = (cx + r > RES - 1) ? RES - 1 : cx + r;
    y_hi    = (cy + r > RES - 1) ? RES - 1 : cy + r;
    z_hi    = (cz + r > RES - 1) ? RES - 1 : cz + r;
    cleared = 0;
    for (int y = y_lo; y <= y_hi; y++) begin
      for (int z = z_lo; z <= z_hi; z++) begin
        for (int x = x_lo; x <= x_hi; x++) begin
          if ((x - cx) * (x - cx) + (y - cy) * (y - cy) + (z - cz) * (z - cz) <= r2) begin
            idx = (z * RES + y) * RES + x;
            if (occupied[idx]) begin
              occupied[idx] = 1'b0;
              cleared++;
            end
          end
        end
      end
    end
    return cleared;
  endfunction

  // Applies one request to the shadow bitmap and returns the result it must give.
  function automatic vos_pkg::vos_rsp_t predict_result(vos_pkg::vos_req_t r);
    vos_pkg::vos_rsp_t res;
    int                x, y, z, idx;
    res = '0;
    x   = $signed(r.coord_x);
    y   = $signed(r.coord_y);
    z   = $signed(r.coord_z);
    idx = (z * RES + y) * RES + x;
    unique case (r.opcode)
      vos_pkg::OP_TEST: begin
        if (in_cube(x, y, z)) res.flag = occupied[idx];
      end
      vos_pkg::OP_SET: begin
        if (in_cube(x, y, z)) begin
          res.flag     = (occupied[idx] != r.new_value);
          occupied[idx] = r.new_value;
        end
      end
      vos_pkg::OP_CARVE: begin
        res.removed_count = vos_pkg::CNT_W'(carve_sphere(x, y, z, int'(r.radius)));
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic note_failure(string msg);
    if (failures < REPORT_LIMIT) $display("ERROR: %s", msg);
    failures++;
  endtask

  // Requests are predicted before results are matched, so a request and a
  // result on the same edge keep their order.
  always @(posedge clk) begin
    vos_pkg::vos_rsp_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) occupied[i] = 1'b1;
      pending_results.delete();
    end else begin
      if (start && !busy) pending_results.push_back(predict_result(req));
      if (done) begin
        if (pending_results.size() == 0) begin
          note_failure($sformatf("result flag=%0d count=%0d with no request waiting",
                                 rsp.flag, rsp.removed_count));
        end else begin
          want = pending_results.pop_front();
          if (rsp.flag !== want.flag || rsp.removed_count !== want.removed_count) begin
            note_failure($sformatf("expected flag=%0d count=%0d, got flag=%0d count=%0d",
                                   want.flag, want.removed_count,
                                   rsp.flag, rsp.removed_count));
          end
        end
      end
    end
    fail_count  <= failures;
    outstanding <= pending_results.size();
  end

endmodule

// ===== verif/voxel_occupancy_sphere_carve_core_tb.sv =====
// ----------------------------------------------------------------------------
// Voxel occupancy sphere carve core testbench
// Drives a directed set of cell tests, cell sets and sphere clears, then a
// random mix under several sender idling patterns. The checker beside the
// core predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module voxel_occupancy_sphere_carve_core_tb;

  localparam int         RES             = vos_pkg::RES_DEFAULT;
  localparam int         RANDOM_REQUESTS = 116;
  localparam int         PHASE_LENGTH    = 29;
  localparam int         STALL_LIMIT     = 20000;
  localparam int         SETTLE_CYCLES   = 16;
  localparam logic [1:0] OP_UNUSED       = 2'd3;

  logic              clk   = 1'b0;
  logic              rst   = 1'b1;
  logic              start = 1'b0;
  vos_pkg::vos_req_t req   = '0;
  logic              busy;
  logic              done;
  vos_pkg::vos_rsp_t rsp;
  int                fail_count;
  int                outstanding;
  int                quiet_cycles = 0;

  voxel_occupancy_sphere_carve_core dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  voxel_occupancy_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  // Ends the run when neither a request nor a result moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic vos_pkg::vos_req_t make_request(logic [1:0] op, int x, int y, int z,
                                                     logic value, int rad);
    vos_pkg::vos_req_t r;
    r.opcode    = op;
    r.coord_x   = 8'(x);
    r.coord_y   = 8'(y);
    r.coord_z   = 8'(z);
    r.new_value = value;
    r.radius    = 8'(rad);
    return r;
  endfunction

  // Mostly inside the cube, some just around its faces, a few anywhere.
  function automatic logic [7:0] random_coord(int spread);
    if (spread < 70) return 8'($urandom_range(RES - 1));
    if (spread < 88) return 8'(int'($urandom_range(RES + 3)) - 2);
    return 8'($urandom_range(255));
  endfunction

  function automatic vos_pkg::vos_req_t random_request();
    vos_pkg::vos_req_t r;
    int                pick, spread;
    pick   = $urandom_range(99);
    spread = $urandom_range(99);
    if (pick < 35)      r.opcode = vos_pkg::OP_TEST;
    else if (pick < 75) r.opcode = vos_pkg::OP_SET;
    else if (pick < 95) r.opcode = vos_pkg::OP_CARVE;
    else                r.opcode = OP_UNUSED;
    r.coord_x   = random_coord(spread);
    r.coord_y   = random_coord(spread);
    r.coord_z   = random_coord(spread);
    // Sets lean toward occupied so that carves keep finding cells to clear.
    r.new_value = ($urandom_range(99) < 65);
    pick        = $urandom_range(99);
    if (r.opcode != vos_pkg::OP_CARVE || pick >= 96) r.radius = 8'($urandom_range(255));
    else if (pick < 80)                              r.radius = 8'($urandom_range(4));
    else                                             r.radius = 8'($urandom_range(RES, 5));
    return r;
  endfunction

  // Presents one request after an optional idle gap and returns once it is taken.
  // Start stays high between back-to-back requests.
  task automatic send_request(vos_pkg::vos_req_t r, int idle_pct);
    while (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int idle_pct;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: cube corners and faces, cell writes, sphere edge cases.
    send_request(make_request(vos_pkg::OP_TEST, 0, 0, 0, 1'b0, 0), 0);
    send_request(make_request(vos_pkg::OP_TEST, 15, 15, 15, 1'b1, 255), 0);
    send_request(make_request(vos_pkg::OP_TEST, -1, 0, 0, 1'b0, 0), 0);
    send_request(make_request(vos_pkg::OP_TEST, 0, 16, 0, 1'b0, 0), 0);
    send_request(make_request(vos_pkg::OP_TEST, 127, -128, 5, 1'b1, 128), 0);
    send_request(make_request(vos_pkg::OP_SET, 3, 4, 5, 1'b0, 0), 0);
    send_request(make_request(vos_pkg::OP_SET, 3, 4, 5, 1'b0, 0), 0);
    send_request(make_request(vos_pkg::OP_TEST, 3, 4, 5, 1'b0, 0), 0);
    send_request(make_request(vos_pkg::OP_SET, 3, 4, 5, 1'b1, 0), 0);
    send_request(make_request(vos_pkg::OP_SET, -128, 127, 0, 1'b0, 0), 0);
    send_request(make_request(vos_pkg::OP_SET, 15, 0, 15, 1'b0, 0), 0);
    // Radius zero clears only the centre, and only once.
    send_request(make_request(vos_pkg::OP_CARVE, 8, 8, 8, 1'b0, 0), 0);
    send_request(make_request(vos_pkg::OP_CARVE, 8, 8, 8, 1'b0, 0), 0);
    send_request(make_request(vos_pkg::OP_CARVE, 20, -5, 3, 1'b0, 0), 0);
    // Centre outside the cube with the box partly inside it.
    send_request(make_request(vos_pkg::OP_CARVE, -3, 8, 8, 1'b0, 5), 0);
    send_request(make_request(vos_pkg::OP_CARVE, 4, 4, 4, 1'b0, 2), 0);
    // Centre so far out that the clipped box is empty.
    send_request(make_request(vos_pkg::OP_CARVE, -128, -128, -128, 1'b0, 255), 0);
    send_request(make_request(vos_pkg::OP_CARVE, 127, 127, 127, 1'b1, 255), 0);
    send_request(make_request(OP_UNUSED, 1, 2, 3, 1'b1, 9), 0);
    // Radius above the cube size is clamped and empties everything left.
    send_request(make_request(vos_pkg::OP_CARVE, 8, 8, 8, 1'b0, 255), 0);
    send_request(make_request(vos_pkg::OP_TEST, 0, 0, 0, 1'b0, 0), 0);
    send_request(make_request(vos_pkg::OP_SET, 0, 0, 0, 1'b1, 0), 0);
    send_request(make_request(vos_pkg::OP_SET, 15, 15, 15, 1'b1, 0), 0);
    send_request(make_request(vos_pkg::OP_CARVE, 0, 0, 0, 1'b0, 16), 0);

    // Random mix; the sender idling pattern changes every phase.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      unique case ((i / PHASE_LENGTH) % 4)
        0:       idle_pct = 0;
        1:       idle_pct = 82;
        2:       idle_pct = 19;
        default: idle_pct = 0;
      endcase
      send_request(random_request(), idle_pct);
    end
    start <= 1'b0;

    // Wait for every predicted result, then let the core settle.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
